[rtl/tlr_pkg.sv]
// tlr_pkg: shared types and constants of the thick line rasterizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tlr_pkg;

    localparam int CANVAS_BITS  = 12;
    localparam int THICK_BITS   = 3;
    localparam int COLOR_BITS   = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 24;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CANVAS_WIDTH    = 2'd0,
        CFG_CANVAS_HEIGHT   = 2'd1,
        CFG_BRUSH_THICKNESS = 2'd2,
        CFG_DRAW_COLOR      = 2'd3
    } cfg_index_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [CANVAS_BITS-1:0] RST_CANVAS_WIDTH    = 12'd640;
    localparam logic [CANVAS_BITS-1:0] RST_CANVAS_HEIGHT   = 12'd480;
    localparam logic [THICK_BITS-1:0]  RST_BRUSH_THICKNESS = 3'd3;
    localparam logic [COLOR_BITS-1:0]  RST_DRAW_COLOR      = 24'd0;

    typedef struct packed {
        logic [CANVAS_BITS-1:0] canvas_width;
        logic [CANVAS_BITS-1:0] canvas_height;
        logic [THICK_BITS-1:0]  brush_thickness;
        logic [COLOR_BITS-1:0]  draw_color;
    } cfg_t;

    typedef struct packed {
        logic                   has_pixels;
        logic                   line_done;
        logic [CANVAS_BITS-1:0] x_lo;
        logic [CANVAS_BITS-1:0] x_hi;
        logic [CANVAS_BITS-1:0] y_lo;
        logic [CANVAS_BITS-1:0] y_hi;
        logic [COLOR_BITS-1:0]  color;
    } stamp_job_t;

endpackage

[rtl/tlr_item_if.sv]
// tlr_item_if: input item channel (opcode and line endpoints)
// depends on nothing
`timescale 1ns / 1ps

interface tlr_item_if #(
    parameter int COORD_BITS = 13
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

[rtl/tlr_pixel_if.sv]
// tlr_pixel_if: result channel, one stamp pixel per beat
// depends on nothing
`timescale 1ns / 1ps

interface tlr_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        pixel_valid;
    logic [23:0] pixel_color;
    logic        last_of_step;
    logic        line_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_valid, pixel_color, last_of_step,
               line_done,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_valid, pixel_color, last_of_step,
               line_done,
        output ready
    );
endinterface

[rtl/tlr_cfg_if.sv]
// tlr_cfg_if: configuration write channel, register index and data
// depends on nothing
`timescale 1ns / 1ps

interface tlr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/tlr_walker.sv]
// tlr_walker: input register, Bresenham walk state and stamp bound setup
// depends on tlr_pkg and tlr_item_if
`timescale 1ns / 1ps

module tlr_walker #(
    parameter int COORD_BITS = 13,
    parameter int MAX_RADIUS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    tlr_item_if.sink           item,
    input  tlr_pkg::cfg_t      cfg,
    output logic               job_valid,
    output tlr_pkg::stamp_job_t job,
    input  logic               job_ready
);
    import tlr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int EW = CW + 3;
    localparam int SW = (CW > CANVAS_BITS ? CW : CANVAS_BITS) + 2;

    // input register
    logic                 hold_reg;
    logic                 op_reg;
    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    // walk state
    logic signed [CW-1:0] px_reg, py_reg, tx_reg, ty_reg;
    logic        [DW-1:0] dx_reg;
    logic signed [DW-1:0] ndy_reg;
    logic        [1:0]    dirs_reg;
    logic signed [EW-1:0] err_reg;
    logic                 active_reg;

    logic                 accept;
    logic                 consume;

    logic signed [DW-1:0] x0e, y0e, x1e, y1e;
    logic        [DW-1:0] dx_load;
    logic signed [DW-1:0] ndy_load;
    logic signed [EW-1:0] err_load;
    logic        [1:0]    dirs_load;

    logic                 at_end;
    logic signed [EW:0]   e2;
    logic                 step_x, step_y;
    logic signed [EW-1:0] add_x, add_y;
    logic signed [EW-1:0] err_adv;
    logic signed [CW-1:0] px_adv, py_adv;

    logic [1:0]           half;
    logic [1:0]           rad;
    logic signed [SW-1:0] pxs, pys, rs, wm1, hm1;
    logic signed [SW-1:0] xa_raw, xb_raw, ya_raw, yb_raw;
    logic signed [SW-1:0] xa, xb, ya, yb;

    assign accept     = item.valid && item.ready;
    assign consume    = hold_reg && ((op_reg == OP_LOAD) || job_ready);
    assign item.ready = !hold_reg || consume;
    assign job_valid  = hold_reg && (op_reg == OP_ADVANCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_reg <= 1'b1;
        end
        else if (consume)
        begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= item.opcode;
            sx_reg <= item.start_x;
            sy_reg <= item.start_y;
            ex_reg <= item.end_x;
            ey_reg <= item.end_y;
        end
    end

    // load setup
    always_comb
    begin
        x0e       = DW'(sx_reg);
        y0e       = DW'(sy_reg);
        x1e       = DW'(ex_reg);
        y1e       = DW'(ey_reg);
        dx_load   = (x1e > x0e) ? DW'(x1e - x0e) : DW'(x0e - x1e);
        ndy_load  = (y1e > y0e) ? (y0e - y1e) : (y1e - y0e);
        err_load  = $signed(EW'(dx_load)) + EW'(ndy_load);
        dirs_load = {!(y0e < y1e), !(x0e < x1e)};
    end

    // one error-term step
    always_comb
    begin
        at_end  = (px_reg == tx_reg) && (py_reg == ty_reg);
        e2      = {err_reg, 1'b0};
        step_x  = e2 >= (EW+1)'(ndy_reg);
        step_y  = e2 <= $signed((EW+1)'(dx_reg));
        add_x   = step_x ? EW'(ndy_reg) : EW'(0);
        add_y   = step_y ? $signed(EW'(dx_reg)) : EW'(0);
        err_adv = err_reg + add_x + add_y;
        px_adv  = px_reg;
        py_adv  = py_reg;
        if (step_x)
        begin
            px_adv = dirs_reg[0] ? px_reg - CW'(1) : px_reg + CW'(1);
        end
        if (step_y)
        begin
            py_adv = dirs_reg[1] ? py_reg - CW'(1) : py_reg + CW'(1);
        end
    end

    // clipped stamp bounds
    always_comb
    begin
        half   = cfg.brush_thickness[2:1];
        rad    = (int'(half) > MAX_RADIUS) ? 2'(MAX_RADIUS) : half;
        pxs    = SW'(px_reg);
        pys    = SW'(py_reg);
        rs     = $signed(SW'(rad));
        wm1    = $signed(SW'(cfg.canvas_width)) - SW'(1);
        hm1    = $signed(SW'(cfg.canvas_height)) - SW'(1);
        xa_raw = pxs - rs;
        xb_raw = pxs + rs;
        ya_raw = pys - rs;
        yb_raw = pys + rs;
        xa     = (xa_raw < 0) ? SW'(0) : xa_raw;
        ya     = (ya_raw < 0) ? SW'(0) : ya_raw;
        xb     = (xb_raw > wm1) ? wm1 : xb_raw;
        yb     = (yb_raw > hm1) ? hm1 : yb_raw;

        job.has_pixels = active_reg && (xa <= xb) && (ya <= yb);
        job.line_done  = !active_reg || at_end;
        job.x_lo       = xa[CANVAS_BITS-1:0];
        job.x_hi       = xb[CANVAS_BITS-1:0];
        job.y_lo       = ya[CANVAS_BITS-1:0];
        job.y_hi       = yb[CANVAS_BITS-1:0];
        job.color      = cfg.draw_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg     <= '0;
            py_reg     <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            dx_reg     <= '0;
            ndy_reg    <= '0;
            dirs_reg   <= '0;
            err_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (consume)
        begin
            if (op_reg == OP_LOAD)
            begin
                px_reg     <= sx_reg;
                py_reg     <= sy_reg;
                tx_reg     <= ex_reg;
                ty_reg     <= ey_reg;
                dx_reg     <= dx_load;
                ndy_reg    <= ndy_load;
                dirs_reg   <= dirs_load;
                err_reg    <= err_load;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                if (at_end)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    px_reg  <= px_adv;
                    py_reg  <= py_adv;
                    err_reg <= err_adv;
                end
            end
        end
    end

endmodule

[rtl/tlr_stamp.sv]
// tlr_stamp: stamp scanner and result register, one pixel per beat
// depends on tlr_pkg and tlr_pixel_if
`timescale 1ns / 1ps

module tlr_stamp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  tlr_pkg::stamp_job_t job,
    output logic                job_ready,
    tlr_pixel_if.source         pixel
);
    import tlr_pkg::*;

    logic                   busy_reg;
    logic                   has_reg;
    logic                   done_reg;
    logic [CANVAS_BITS-1:0] x_reg, y_reg;
    logic [CANVAS_BITS-1:0] xlo_reg, xhi_reg, yhi_reg;
    logic [COLOR_BITS-1:0]  color_reg;

    logic last;
    logic take;
    logic step;

    assign last      = !has_reg || ((x_reg == xhi_reg) && (y_reg == yhi_reg));
    assign job_ready = !busy_reg || (pixel.ready && last);
    assign take      = job_valid && job_ready;
    assign step      = busy_reg && pixel.ready && !last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
        end
        else if (pixel.ready && last)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            has_reg   <= job.has_pixels;
            done_reg  <= job.line_done;
            x_reg     <= job.x_lo;
            y_reg     <= job.y_lo;
            xlo_reg   <= job.x_lo;
            xhi_reg   <= job.x_hi;
            yhi_reg   <= job.y_hi;
            color_reg <= job.color;
        end
        else if (step)
        begin
            if (x_reg == xhi_reg)
            begin
                x_reg <= xlo_reg;
                y_reg <= y_reg + CANVAS_BITS'(1);
            end
            else
            begin
                x_reg <= x_reg + CANVAS_BITS'(1);
            end
        end
    end

    assign pixel.valid        = busy_reg;
    assign pixel.pixel_x      = has_reg ? x_reg : '0;
    assign pixel.pixel_y      = has_reg ? y_reg : '0;
    assign pixel.pixel_valid  = has_reg;
    assign pixel.pixel_color  = has_reg ? color_reg : '0;
    assign pixel.last_of_step = last;
    assign pixel.line_done    = done_reg;

endmodule

[rtl/thick_line_rasterizer.sv]
// thick_line_rasterizer: top level, configuration registers and the two stages
// depends on tlr_pkg, the channel interfaces, tlr_walker and tlr_stamp
`timescale 1ns / 1ps

// Line walker with a square brush. A load item is held in the input register
// and gives no beat; it overlaps with pixels still going out. An advance item
// gives one result beat per cycle, while the receiver is ready, for each pixel
// of its clipped stamp, so between 1 and (2*MAX_RADIUS+1)^2 beats, nine at
// brush thickness 2 or 3; a fully clipped stamp or an advance with no line
// gives a single beat. The stamp scanner in the output stage moves one pixel
// per beat; a waiting advance starts in the cycle after the last pixel of the
// one before. Configuration writes are taken at once.

module thick_line_rasterizer #(
    parameter int COORD_BITS = 13,
    parameter int MAX_RADIUS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    tlr_item_if.sink    item,
    tlr_cfg_if.sink     cfg,
    tlr_pixel_if.source pixel
);
    import tlr_pkg::*;

    cfg_t       cfg_reg;
    logic       job_valid;
    stamp_job_t job;
    logic       job_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width    <= RST_CANVAS_WIDTH;
            cfg_reg.canvas_height   <= RST_CANVAS_HEIGHT;
            cfg_reg.brush_thickness <= RST_BRUSH_THICKNESS;
            cfg_reg.draw_color      <= RST_DRAW_COLOR;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_CANVAS_WIDTH:    cfg_reg.canvas_width    <= cfg.data[CANVAS_BITS-1:0];
                CFG_CANVAS_HEIGHT:   cfg_reg.canvas_height   <= cfg.data[CANVAS_BITS-1:0];
                CFG_BRUSH_THICKNESS: cfg_reg.brush_thickness <= cfg.data[THICK_BITS-1:0];
                CFG_DRAW_COLOR:      cfg_reg.draw_color      <= cfg.data[COLOR_BITS-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    tlr_walker #(
        .COORD_BITS (COORD_BITS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    tlr_stamp u_stamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .pixel     (pixel)
    );

endmodule

[bench/tb_thick_line_rasterizer.sv]
// tb_thick_line_rasterizer: self-checking bench for the thick line rasterizer
// depends on tlr_pkg, the three channel interfaces and the thick_line_rasterizer top
// loads and advances lines against a bit-exact stamp predictor under random flow control
`timescale 1ns / 1ps

module tb_thick_line_rasterizer;

    import tlr_pkg::*;

    localparam int COORD_W     = 13;
    localparam int RADIUS_CAP  = 3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_GAP  = 12;
    localparam int ITEM_TARGET = 500;

    typedef struct packed {
        logic [CANVAS_BITS-1:0] x;
        logic [CANVAS_BITS-1:0] y;
        logic                   valid;
        logic [COLOR_BITS-1:0]  color;
        logic                   last;
        logic                   done;
    } pixel_beat_t;

    class brush_stamp_predictor;
        logic [CANVAS_BITS-1:0]    canvas_w;
        logic [CANVAS_BITS-1:0]    canvas_h;
        logic [THICK_BITS-1:0]     thickness;
        logic [COLOR_BITS-1:0]     color;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COORD_W:0]          span_x;
        logic signed [COORD_W+1:0] neg_span_y;
        logic [1:0]                dirs;
        logic signed [15:0]        err;
        bit                        active;
        pixel_beat_t               pending_pixels[$];
        int                        mismatches;

        function new();
            canvas_w   = RST_CANVAS_WIDTH;
            canvas_h   = RST_CANVAS_HEIGHT;
            thickness  = RST_BRUSH_THICKNESS;
            color      = RST_DRAW_COLOR;
            cur_x      = '0;
            cur_y      = '0;
            end_x      = '0;
            end_y      = '0;
            span_x     = '0;
            neg_span_y = '0;
            dirs       = '0;
            err        = '0;
            active     = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DAT_BITS-1:0] data);
            case (idx)
                CFG_CANVAS_WIDTH:    canvas_w  = data[CANVAS_BITS-1:0];
                CFG_CANVAS_HEIGHT:   canvas_h  = data[CANVAS_BITS-1:0];
                CFG_BRUSH_THICKNESS: thickness = data[THICK_BITS-1:0];
                CFG_DRAW_COLOR:      color     = data[COLOR_BITS-1:0];
                default:             ;
            endcase
        endfunction

        function void push(int x, int y, bit v, logic [COLOR_BITS-1:0] c, bit last, bit done);
            pixel_beat_t beat;
            beat.x     = CANVAS_BITS'(x);
            beat.y     = CANVAS_BITS'(y);
            beat.valid = v;
            beat.color = c;
            beat.last  = last;
            beat.done  = done;
            pending_pixels.insert(pending_pixels.size(), beat);
        endfunction

        function void accept_item(logic op, logic signed [COORD_W-1:0] sx,
                                  logic signed [COORD_W-1:0] sy,
                                  logic signed [COORD_W-1:0] ex,
                                  logic signed [COORD_W-1:0] ey);
            int  x0, y0, x1, y1;
            int  rad, xa, xb, ya, yb, total, n, e2;
            bit  at_end;
            if (op == OP_LOAD)
            begin
                x0 = sx;
                y0 = sy;
                x1 = ex;
                y1 = ey;
                cur_x      = sx;
                cur_y      = sy;
                end_x      = ex;
                end_y      = ey;
                span_x     = (COORD_W+1)'(x1 > x0 ? x1 - x0 : x0 - x1);
                neg_span_y = (COORD_W+2)'(y1 > y0 ? y0 - y1 : y1 - y0);
                dirs       = {y0 >= y1, x0 >= x1};
                err        = 16'(int'(span_x) + int'(neg_span_y));
                active     = 1'b1;
                return;
            end
            if (!active)
            begin
                push(0, 0, 1'b0, '0, 1'b1, 1'b1);
                return;
            end
            at_end = (cur_x == end_x) && (cur_y == end_y);
            rad = int'(thickness) / 2;
            if (rad > RADIUS_CAP)
                rad = RADIUS_CAP;
            xa = int'(cur_x) - rad;
            xb = int'(cur_x) + rad;
            ya = int'(cur_y) - rad;
            yb = int'(cur_y) + rad;
            if (xa < 0)
                xa = 0;
            if (ya < 0)
                ya = 0;
            if (xb > int'(canvas_w) - 1)
                xb = int'(canvas_w) - 1;
            if (yb > int'(canvas_h) - 1)
                yb = int'(canvas_h) - 1;
            if (xa <= xb && ya <= yb)
            begin
                total = (xb - xa + 1) * (yb - ya + 1);
                n = 0;
                for (int y = ya; y <= yb; y++)
                    for (int x = xa; x <= xb; x++)
                    begin
                        n++;
                        push(x, y, 1'b1, color, n == total, at_end);
                    end
            end
            else
                push(0, 0, 1'b0, '0, 1'b1, at_end);
            if (at_end)
                active = 1'b0;
            else
            begin
                e2 = 2 * int'(err);
                if (e2 >= int'(neg_span_y))
                begin
                    err   = 16'(int'(err) + int'(neg_span_y));
                    cur_x = COORD_W'(int'(cur_x) + (dirs[0] ? -1 : 1));
                end
                if (e2 <= int'(span_x))
                begin
                    err   = 16'(int'(err) + int'(span_x));
                    cur_y = COORD_W'(int'(cur_y) + (dirs[1] ? -1 : 1));
                end
            end
        endfunction

        function void check_pixel(pixel_beat_t got);
            pixel_beat_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel beat: x=%0d y=%0d v=%0b c=%06h last=%0b done=%0b",
                             got.x, got.y, got.valid, got.color, got.last, got.done);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.valid !== want.valid ||
                got.color !== want.color || got.last !== want.last || got.done !== want.done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: want x=%0d y=%0d v=%0b c=%06h last=%0b done=%0b",
                             want.x, want.y, want.valid, want.color, want.last, want.done,
                             " got x=%0d y=%0d v=%0b c=%06h last=%0b done=%0b",
                             got.x, got.y, got.valid, got.color, got.last, got.done);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tlr_item_if #(.COORD_BITS(COORD_W)) item_ch ();
    tlr_cfg_if   cfg_ch ();
    tlr_pixel_if pix_ch ();

    thick_line_rasterizer #(
        .COORD_BITS (COORD_W),
        .MAX_RADIUS (RADIUS_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .cfg   (cfg_ch),
        .pixel (pix_ch)
    );

    brush_stamp_predictor stamps;
    int cycles     = 0;
    int items_sent = 0;
    int burst_left = 0;
    int rx_mode    = 0;
    int rx_window  = 0;
    int rx_tick    = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL thick_line_rasterizer");
            $finish;
        end
    end

    // receiver flow control: windows of always ready, coin flip, periodic and heavy stall
    always @(posedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_mode   = $urandom_range(0, 3);
            rx_window = $urandom_range(16, 160);
        end
        rx_window--;
        rx_tick++;
        case (rx_mode)
            0:       pix_ch.ready <= 1'b1;
            1:       pix_ch.ready <= 1'($urandom_range(0, 1));
            2:       pix_ch.ready <= (rx_tick % 3) != 0;
            default: pix_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        pixel_beat_t beat;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            beat.x     = pix_ch.pixel_x;
            beat.y     = pix_ch.pixel_y;
            beat.valid = pix_ch.pixel_valid;
            beat.color = pix_ch.pixel_color;
            beat.last  = pix_ch.last_of_step;
            beat.done  = pix_ch.line_done;
            stamps.check_pixel(beat);
        end
    end

    task automatic pause_items(int n);
        item_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(logic op, logic signed [COORD_W-1:0] sx,
                             logic signed [COORD_W-1:0] sy,
                             logic signed [COORD_W-1:0] ex,
                             logic signed [COORD_W-1:0] ey);
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= op;
        item_ch.start_x <= sx;
        item_ch.start_y <= sy;
        item_ch.end_x   <= ex;
        item_ch.end_y   <= ey;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        stamps.accept_item(op, sx, sy, ex, ey);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            pause_items($urandom_range(1, 10));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic advance_line();
        send_item(OP_ADVANCE, COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // drain all pending pixels, then give an in-flight load time to land
    task automatic settle();
        pause_items(1);
        while (stamps.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DAT_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        stamps.write_reg(idx, data);
    endtask

    task automatic write_config(int w, int h, int thick, logic [COLOR_BITS-1:0] c);
        settle();
        write_reg(CFG_CANVAS_WIDTH, CFG_DAT_BITS'(w));
        write_reg(CFG_CANVAS_HEIGHT, CFG_DAT_BITS'(h));
        write_reg(CFG_BRUSH_THICKNESS, CFG_DAT_BITS'(thick));
        write_reg(CFG_DRAW_COLOR, CFG_DAT_BITS'(c));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_coord(int limit);
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 12)) - 6;
            1:       return limit + int'($urandom_range(0, 12)) - 6;
            2:       return int'($urandom_range(0, limit));
            default: return int'($urandom_range(0, 8191)) - 4096;
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 4095;
            3:       return $urandom_range(2, 4095);
            default: return $urandom_range(2, 48);
        endcase
    endfunction

    task automatic draw_line(int w, int h);
        logic signed [COORD_W-1:0] x0, y0, x1, y1;
        int dx, dy, span, steps;
        x0 = COORD_W'(pick_coord(w));
        y0 = COORD_W'(pick_coord(h));
        if ($urandom_range(0, 9) == 0)
        begin
            x1 = COORD_W'($urandom);
            y1 = COORD_W'($urandom);
        end
        else
        begin
            x1 = COORD_W'(int'(x0) + int'($urandom_range(0, 20)) - 10);
            y1 = COORD_W'(int'(y0) + int'($urandom_range(0, 20)) - 10);
        end
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        span = ((dx > dy) ? dx : dy) + 1;
        steps = (span > 40) ? $urandom_range(1, 6) : span + $urandom_range(0, 2);
        // some lines are dropped partway by the next load
        if (steps > 1 && $urandom_range(0, 7) == 0)
            steps = $urandom_range(1, steps - 1);
        send_item(OP_LOAD, x0, y0, x1, y1);
        repeat (steps) advance_line();
    endtask

    task automatic random_items(int target, int w, int h);
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) != 0)
                draw_line(w, h);
            else if ($urandom_range(0, 1) == 0)
                send_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom));
            else
                advance_line();
        end
    endtask

    initial
    begin
        int w, h, thick, phase;
        logic [COLOR_BITS-1:0] c;
        stamps = new();
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = OP_LOAD;
        item_ch.start_x = '0;
        item_ch.start_y = '0;
        item_ch.end_x   = '0;
        item_ch.end_y   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_CANVAS_WIDTH;
        cfg_ch.data     = '0;
        pix_ch.ready    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines on the reset canvas
        advance_line();
        send_item(OP_LOAD, COORD_W'(0), COORD_W'(0), COORD_W'(0), COORD_W'(0));
        advance_line();
        advance_line();
        send_item(OP_LOAD, COORD_W'(-4096), COORD_W'(-4096), COORD_W'(4095), COORD_W'(4095));
        advance_line();
        advance_line();
        send_item(OP_LOAD, COORD_W'(639), COORD_W'(479), COORD_W'(636), COORD_W'(477));
        repeat (4) advance_line();
        send_item(OP_LOAD, COORD_W'(4095), COORD_W'(-4096), COORD_W'(-4096), COORD_W'(4095));
        advance_line();
        send_item(OP_LOAD, COORD_W'(5), COORD_W'(20), COORD_W'(3), COORD_W'(10));
        repeat (3) advance_line();
        send_item(OP_LOAD, COORD_W'(700), COORD_W'(100), COORD_W'(700), COORD_W'(100));
        advance_line();
        send_item(OP_LOAD, COORD_W'(2), COORD_W'(478), COORD_W'(-1), COORD_W'(481));
        repeat (4) advance_line();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase)
                0:
                begin
                    w = 4095; h = 4095; thick = 7; c = 24'hFFFFFF;
                end
                1:
                begin
                    w = 0; h = 1; thick = 0; c = 24'h000000;
                end
                2:
                begin
                    w = 1; h = 0; thick = 1; c = COLOR_BITS'($urandom);
                end
                3:
                begin
                    w = 1; h = 1; thick = 2; c = COLOR_BITS'($urandom);
                end
                default:
                begin
                    w = pick_size();
                    h = pick_size();
                    thick = $urandom_range(0, 7);
                    case ($urandom_range(0, 3))
                        0:       c = '0;
                        1:       c = '1;
                        default: c = COLOR_BITS'($urandom);
                    endcase
                end
            endcase
            write_config(w, h, thick, c);
            random_items(items_sent + 50, w, h);
            phase++;
        end

        settle();
        if (stamps.mismatches == 0 && stamps.pending_pixels.size() == 0)
            $display("PASS thick_line_rasterizer");
        else
            $display("FAIL thick_line_rasterizer");
        $finish;
    end

endmodule
